>>> hdl/csia_pkg.sv
package csia_pkg;

	// field widths of the item and result words
	localparam int CODE_W      = 20;
	localparam int KEY_W       = 17;
	localparam int SUM_W       = 23;
	localparam int POS_W       = 7;
	localparam int CLS_W       = 2;
	localparam int STAT_W      = 3;
	localparam int RIDX_W      = 6;
	localparam int NUM_CLASSES = 3;

	// divide by ten: key = (code * RECIP_MUL) >> RECIP_SHIFT, exact for 20-bit codes
	localparam logic [CODE_W-1:0] RECIP_MUL   = 20'd838861;
	localparam int                RECIP_SHIFT = 23;
	localparam logic [3:0]        DIGIT_BASE  = 4'd10;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_INSERTED = 3'd0,
		STAT_IGNORED  = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_READ_OK  = 3'd3,
		STAT_READ_BAD = 3'd4
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SPLIT,
		S_CLASS,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_RD_WAIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic  load;
		logic  split;
		logic  scan_init;
		logic  rd_en;
		logic  rd_idx;
		logic  wr_en;
		logic  wr_key;
		logic  ptr_dec;
		logic  commit;
		logic  emit;
		stat_t stat;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_read;
		logic cls_zero;
		logic full;
		logic read_bad;
		logic ptr_zero;
		logic greater;
	} sts_t;

endpackage

>>> hdl/csia_ctrl.sv
module csia_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  csia_pkg::sts_t    sts,
	output csia_pkg::cmd_t    cmd
);

	csia_pkg::state_t st_q;
	csia_pkg::state_t nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= csia_pkg::S_IDLE;
		end else begin
			st_q <= nxt;
		end
	end

	// next state and commands
	always_comb begin
		nxt      = st_q;
		cmd      = '0;
		cmd.stat = csia_pkg::STAT_INSERTED;
		unique case (st_q)
			csia_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					nxt      = csia_pkg::S_SPLIT;
				end
			end
			csia_pkg::S_SPLIT: begin
				cmd.split = 1'b1;
				nxt       = csia_pkg::S_CLASS;
			end
			csia_pkg::S_CLASS: begin
				priority if (sts.is_read && sts.read_bad) begin
					cmd.emit = 1'b1;
					cmd.stat = csia_pkg::STAT_READ_BAD;
					nxt      = csia_pkg::S_IDLE;
				end else if (sts.is_read) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_idx = 1'b1;
					nxt        = csia_pkg::S_RD_WAIT;
				end else if (sts.cls_zero) begin
					cmd.emit = 1'b1;
					cmd.stat = csia_pkg::STAT_IGNORED;
					nxt      = csia_pkg::S_IDLE;
				end else if (sts.full) begin
					cmd.emit = 1'b1;
					cmd.stat = csia_pkg::STAT_FULL;
					nxt      = csia_pkg::S_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					nxt           = csia_pkg::S_SCAN_RD;
				end
			end
			csia_pkg::S_SCAN_RD: begin
				// bottom reached: key goes to slot zero
				if (sts.ptr_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_key = 1'b1;
					cmd.commit = 1'b1;
					cmd.emit   = 1'b1;
					cmd.stat   = csia_pkg::STAT_INSERTED;
					nxt        = csia_pkg::S_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					nxt       = csia_pkg::S_SCAN_CMP;
				end
			end
			csia_pkg::S_SCAN_CMP: begin
				// shift a larger entry up, or drop the key in above it
				if (sts.greater) begin
					cmd.wr_en   = 1'b1;
					cmd.ptr_dec = 1'b1;
					nxt         = csia_pkg::S_SCAN_RD;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_key = 1'b1;
					cmd.commit = 1'b1;
					cmd.emit   = 1'b1;
					cmd.stat   = csia_pkg::STAT_INSERTED;
					nxt        = csia_pkg::S_IDLE;
				end
			end
			csia_pkg::S_RD_WAIT: begin
				cmd.emit = 1'b1;
				cmd.stat = csia_pkg::STAT_READ_OK;
				nxt      = csia_pkg::S_IDLE;
			end
			default: begin
				nxt = csia_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (st_q != csia_pkg::S_IDLE);

`ifndef SYNTHESIS
	a_idle_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(cmd.emit))
		else $error("controller left work without a result");

	a_wr_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (st_q == csia_pkg::S_SCAN_RD || st_q == csia_pkg::S_SCAN_CMP))
		else $error("store write outside the insert scan");

	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (st_q == csia_pkg::S_SPLIT))
		else $error("load did not start the split step");
`endif

endmodule

>>> hdl/csia_datapath.sv
module csia_datapath #(
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  csia_pkg::cmd_t                 cmd,
	output csia_pkg::sts_t                 sts,
	input  logic                           kind,
	input  logic [csia_pkg::CODE_W-1:0]    code,
	input  logic [csia_pkg::CLS_W-1:0]     read_class,
	input  logic [csia_pkg::RIDX_W-1:0]    read_index,
	output logic                           done,
	output logic [csia_pkg::STAT_W-1:0]    status,
	output logic [csia_pkg::CLS_W-1:0]     class_id,
	output logic [csia_pkg::KEY_W-1:0]     key_value,
	output logic [csia_pkg::POS_W-1:0]     position,
	output logic [csia_pkg::POS_W-1:0]     class_count,
	output logic [csia_pkg::SUM_W-1:0]     class_sum
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// captured word
	logic                          kind_q;
	logic [csia_pkg::CODE_W-1:0]   code_q;
	logic [csia_pkg::CLS_W-1:0]    rcls_q;
	logic [csia_pkg::RIDX_W-1:0]   ridx_q;
	logic [csia_pkg::KEY_W-1:0]    key_q;
	logic [CW-1:0]                 ptr_q;
	logic [csia_pkg::KEY_W-1:0]    rdata_q;

	// per-class counts and sums
	logic [CW-1:0]                 cnt_q [csia_pkg::NUM_CLASSES];
	logic [csia_pkg::SUM_W-1:0]    sum_q [csia_pkg::NUM_CLASSES];

	// sorted stores, one row per class
	logic [csia_pkg::KEY_W-1:0]    store_q [csia_pkg::NUM_CLASSES][DEPTH];

	logic [2*csia_pkg::CODE_W-1:0] prod;
	logic [3:0]                    digit;
	logic [csia_pkg::CLS_W-1:0]    cls;
	logic [csia_pkg::CLS_W-1:0]    cls_idx;
	logic [CW-1:0]                 cnt_sel;
	logic [csia_pkg::SUM_W-1:0]    sum_sel;
	logic [CW-1:0]                 ptr_m1;
	logic [IW-1:0]                 rd_addr;
	logic [IW-1:0]                 wr_addr;
	logic [csia_pkg::KEY_W-1:0]    wr_data;
	logic [CW-1:0]                 new_cnt;
	logic [csia_pkg::SUM_W:0]      sum_ext;
	logic [csia_pkg::SUM_W-1:0]    new_sum;

	logic                          done_q;
	csia_pkg::stat_t               res_stat_q;
	logic [csia_pkg::CLS_W-1:0]    res_cls_q;
	logic [csia_pkg::KEY_W-1:0]    res_key_q;
	logic [csia_pkg::POS_W-1:0]    res_pos_q;
	logic [csia_pkg::POS_W-1:0]    res_cnt_q;
	logic [csia_pkg::SUM_W-1:0]    res_sum_q;

	logic [csia_pkg::CLS_W-1:0]    res_cls;
	logic [csia_pkg::KEY_W-1:0]    res_key;
	logic [csia_pkg::POS_W-1:0]    res_pos;
	logic [csia_pkg::POS_W-1:0]    res_cnt;
	logic [csia_pkg::SUM_W-1:0]    res_sum;

	// quotient by ten through the reciprocal
	assign prod = code_q * csia_pkg::RECIP_MUL;

	// class digit from the low bits of code - 10 * key
	always_comb begin
		digit = code_q[3:0] - 4'(key_q[3:0] * csia_pkg::DIGIT_BASE);
		if (kind_q == csia_pkg::KIND_READ) begin
			cls = rcls_q;
		end else if (digit >= 4'd1 && digit <= 4'(csia_pkg::NUM_CLASSES)) begin
			cls = digit[csia_pkg::CLS_W-1:0];
		end else begin
			cls = '0;
		end
	end

	assign cls_idx = cls - 2'd1;

	// select the count and sum of the class, zero when no class applies
	always_comb begin
		if (cls == '0) begin
			cnt_sel = '0;
			sum_sel = '0;
		end else begin
			cnt_sel = cnt_q[cls_idx];
			sum_sel = sum_q[cls_idx];
		end
	end

	assign ptr_m1  = ptr_q - CW'(1);
	assign rd_addr = cmd.rd_idx ? IW'(ridx_q) : ptr_m1[IW-1:0];
	assign wr_addr = ptr_q[IW-1:0];
	assign wr_data = cmd.wr_key ? key_q : rdata_q;
	assign new_cnt = cnt_sel + CW'(1);
	assign sum_ext = {1'b0, sum_sel} + (csia_pkg::SUM_W + 1)'(key_q);
	assign new_sum = sum_ext[csia_pkg::SUM_W] ? csia_pkg::SUM_MAX
		: sum_ext[csia_pkg::SUM_W-1:0];

	// status toward the controller
	always_comb begin
		sts.is_read  = (kind_q == csia_pkg::KIND_READ);
		sts.cls_zero = (cls == '0);
		sts.full     = (cnt_sel >= CW'(DEPTH));
		sts.read_bad = (cls == '0) || (32'(ridx_q) >= 32'(cnt_sel))
			|| (32'(ridx_q) >= 32'(DEPTH));
		sts.ptr_zero = (ptr_q == '0);
		sts.greater  = (rdata_q > key_q);
	end

	// capture the word, split the code, walk the insert pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			code_q <= code;
			rcls_q <= read_class;
			ridx_q <= read_index;
		end
		if (cmd.split) begin
			key_q <= prod[csia_pkg::RECIP_SHIFT +: csia_pkg::KEY_W];
		end
		if (cmd.scan_init) begin
			ptr_q <= cnt_sel;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_m1;
		end
	end

	// store: one write and one registered read per cycle, each on its enable
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			store_q[cls_idx][wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= store_q[cls_idx][rd_addr];
		end
	end

	// advance count and sum of the class on a completed insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < csia_pkg::NUM_CLASSES; i++) begin
				cnt_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			cnt_q[cls_idx] <= new_cnt;
			sum_q[cls_idx] <= new_sum;
		end
	end

	// build the result word
	always_comb begin
		res_cls = cls;
		res_key = key_q;
		res_pos = '0;
		res_cnt = csia_pkg::POS_W'(cnt_sel);
		res_sum = sum_sel;
		unique case (cmd.stat)
			csia_pkg::STAT_INSERTED: begin
				res_pos = csia_pkg::POS_W'(ptr_q);
				res_cnt = csia_pkg::POS_W'(new_cnt);
				res_sum = new_sum;
			end
			csia_pkg::STAT_IGNORED: begin
				res_cls = '0;
			end
			csia_pkg::STAT_FULL: begin
				res_pos = '0;
			end
			csia_pkg::STAT_READ_OK: begin
				res_key = rdata_q;
				res_pos = csia_pkg::POS_W'(ridx_q);
			end
			csia_pkg::STAT_READ_BAD: begin
				res_key = '0;
				res_pos = csia_pkg::POS_W'(ridx_q);
			end
			default: begin
				res_cls = '0;
				res_key = '0;
				res_cnt = '0;
				res_sum = '0;
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_stat_q <= cmd.stat;
			res_cls_q  <= res_cls;
			res_key_q  <= res_key;
			res_pos_q  <= res_pos;
			res_cnt_q  <= res_cnt;
			res_sum_q  <= res_sum;
		end
	end

	assign done        = done_q;
	assign status      = res_stat_q;
	assign class_id    = res_cls_q;
	assign key_value   = res_key_q;
	assign position    = res_pos_q;
	assign class_count = res_cnt_q;
	assign class_sum   = res_sum_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CW'(DEPTH) && cnt_q[1] <= CW'(DEPTH) && cnt_q[2] <= CW'(DEPTH))
		else $error("class count beyond store depth");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!sts.full && !sts.cls_zero))
		else $error("insert committed into a full or missing class");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");
`endif

endmodule

>>> hdl/class_sorted_insert_accumulate_top.sv
// Sorted per-class insert with running sums.
// Input: drive kind, code, read_class, read_index and raise start; the word is
// taken at the rising edge where start is high and busy is low. An insert word
// (kind 0) splits code into key = code / 10 and class digit = code mod 10; a
// key of class 1..3 goes into that class's ascending store behind equal keys
// and adds into the class sum (saturating). A read word (kind 1) returns the
// entry at read_index of class read_class.
// Output: one result word per input word, shown for exactly one cycle with
// done high. The receiver cannot hold it off; it must take it in that cycle.
// Steps: the taking edge loads the word, the split step forms key and class
// digit, and the class step emits the result for ignored inserts, store-full
// inserts and reads of a missing class or past the count; other reads wait on
// the registered store read, and inserts go on to the scan below.
// The insert walks down from the top of the store through a single read port
// and a single write port, moving each larger entry up one slot; one word is in
// work at a time, and busy drops in the cycle the result is shown, so the next
// word can be taken there.
// Reset clears counts and sums at once; store contents need no clearing and
// the block takes words from the first cycle after reset.
module class_sorted_insert_accumulate_top #(
	parameter int STORE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           kind,
	input  logic [csia_pkg::CODE_W-1:0]    code,
	input  logic [csia_pkg::CLS_W-1:0]     read_class,
	input  logic [csia_pkg::RIDX_W-1:0]    read_index,
	output logic                           done,
	output logic [csia_pkg::STAT_W-1:0]    status,
	output logic [csia_pkg::CLS_W-1:0]     class_id,
	output logic [csia_pkg::KEY_W-1:0]     key_value,
	output logic [csia_pkg::POS_W-1:0]     position,
	output logic [csia_pkg::POS_W-1:0]     class_count,
	output logic [csia_pkg::SUM_W-1:0]     class_sum
);

	csia_pkg::cmd_t cmd;
	csia_pkg::sts_t sts;

	// sequencer
	csia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// stores, counts, sums and result register
	csia_datapath #(
		.DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.code        (code),
		.read_class  (read_class),
		.read_index  (read_index),
		.done        (done),
		.status      (status),
		.class_id    (class_id),
		.key_value   (key_value),
		.position    (position),
		.class_count (class_count),
		.class_sum   (class_sum)
	);

endmodule
